@@ design/bbd_pkg.sv @@
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types, constants and the color filter table for the bilinear
// Bayer demosaic.
// ----------------------------------------------------------------------------
package bbd_pkg;

  localparam int PIX_W       = 8;
  localparam int ROW_W       = 2 * PIX_W;   // line store word: {upper, middle}
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int PHASE_W     = 3;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = CFG_DATA_W'(1280);
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = CFG_DATA_W'(720);
  localparam logic [PHASE_W-1:0]    RST_FILTER_PHASE = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_FILTER_PHASE = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    COL_RED   = 2'd0,
    COL_GREEN = 2'd1,
    COL_BLUE  = 2'd2
  } colour_e;

  // Indexed by {phase[1:0], row lsb, column lsb}.
  localparam colour_e COLOUR_TABLE [16] = '{
    COL_RED,   COL_GREEN, COL_GREEN, COL_BLUE,   // RG
    COL_BLUE,  COL_GREEN, COL_GREEN, COL_RED,    // BG
    COL_GREEN, COL_RED,   COL_BLUE,  COL_GREEN,  // GR
    COL_GREEN, COL_BLUE,  COL_RED,   COL_GREEN   // GB
  };

  function automatic colour_e colour_of(input logic [1:0] phase, input logic oy,
                                        input logic ox);
    return COLOUR_TABLE[{phase, oy, ox}];
  endfunction

  // Request moving from the control stage into the window stage.
  typedef struct packed {
    logic             fwd;     // line store word comes from the last write
    logic             wr;      // update line stores
    logic             shift;   // shift a new column into the window
    logic             emit;    // produce an output pixel
    logic             pre;     // output uses the window before the shift
    logic             ox_lsb;
    logic             oy_lsb;
    logic             ledge;   // left neighbor replicated
    logic             redge;   // right neighbor replicated
    logic             top;     // top neighbor replicated
    logic             bedge;   // bottom neighbor replicated
    logic [PIX_W-1:0] pix;
  } bbd_s1_t;

  // Edge-resolved neighborhood of one output pixel.
  typedef struct packed {
    logic [PIX_W-1:0] ctr;
    logic [PIX_W-1:0] lm;
    logic [PIX_W-1:0] rm;
    logic [PIX_W-1:0] ct;
    logic [PIX_W-1:0] cb;
    logic [PIX_W-1:0] lt;
    logic [PIX_W-1:0] rt;
    logic [PIX_W-1:0] lb;
    logic [PIX_W-1:0] rb;
    logic             ox_lsb;
    logic             oy_lsb;
    logic             eof;
  } bbd_nbhd_t;

endpackage

@@ design/bbd_ram.sv @@
// ----------------------------------------------------------------------------
// bbd_ram
// Simple dual-port RAM, one write and one registered read port.
// A read and a write to the same address return the old word.
// ----------------------------------------------------------------------------
module bbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/bbd_ctrl.sv @@
// ----------------------------------------------------------------------------
// bbd_ctrl
// Input position counters, per-item decisions and line store read issue.
// Holds the request register in front of the window stage.
// ----------------------------------------------------------------------------
module bbd_ctrl import bbd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int RW = $clog2(MAX_HEIGHT + 2)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CFG_DATA_W-1:0] frame_width_i,
  input  logic [CFG_DATA_W-1:0] frame_height_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  win_ready_i,
  output logic                  ram_re_o,
  output logic [CW-1:0]         ram_raddr_o,
  output logic                  s1_valid_o,
  output bbd_s1_t               s1_o,
  output logic [CW-1:0]         s1_addr_o
);

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  logic [CW-1:0] c_q, c_d;
  logic [RW-1:0] r_q, r_d;
  logic          s1_valid_q, s1_valid_d;
  bbd_s1_t       s1_q, s1_d;
  logic [CW-1:0] s1_addr_q;

  logic accept, is_drain, ignore, is_final, load, wrap;
  logic r_lt, r_gt, r_ge1, r_ge2, r_is1, r_is2;
  logic c_is0, c_is1, c_ge_w, w_is1;

  always_comb begin
    if (frame_width_i == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width_i) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_i);
    end
    if (frame_height_i == '0) begin
      h_eff = HW'(1);
    end else if (32'(frame_height_i) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height_i);
    end
  end

  assign s_axis_tready = !s1_valid_q || win_ready_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_drain      = (op_e'(s_axis_tuser) == OP_DRAIN);

  assign r_lt  = r_q < RW'(h_eff);
  assign r_gt  = r_q > RW'(h_eff);
  assign r_ge1 = r_q >= RW'(1);
  assign r_ge2 = r_q >= RW'(2);
  assign r_is1 = r_q == RW'(1);
  assign r_is2 = r_q == RW'(2);

  assign c_is0  = c_q == '0;
  assign c_is1  = c_q == CW'(1);
  assign c_ge_w = (WW+1)'(c_q) >= (WW+1)'(w_eff);
  assign wrap   = ((WW+1)'(c_q) + (WW+1)'(1)) >= (WW+1)'(w_eff);
  assign w_is1  = w_eff == WW'(1);

  assign ignore   = r_lt && is_drain;
  assign is_final = r_gt;
  assign load     = accept && !ignore;

  always_comb begin
    c_d = c_q;
    r_d = r_q;
    s1_d.fwd   = s1_valid_q && win_ready_i && s1_q.wr && (s1_addr_q == c_q);
    s1_d.pix   = s_axis_tdata[PIX_W-1:0];
    s1_d.wr    = r_lt && !is_final;
    s1_d.shift = !is_final;
    s1_d.pre   = is_final || c_is0;
    s1_d.emit  = is_final || (c_is0 ? r_ge2 : r_ge1);
    if (is_final || c_is0) begin
      // last pixel of the row before
      s1_d.ox_lsb = ~w_eff[0];
      s1_d.ledge  = w_is1;
      s1_d.redge  = 1'b1;
      s1_d.oy_lsb = r_q[0];
      s1_d.top    = r_is2;
      s1_d.bedge  = r_gt;
    end else begin
      s1_d.ox_lsb = ~c_q[0];
      s1_d.ledge  = c_is1;
      s1_d.redge  = c_ge_w;
      s1_d.oy_lsb = ~r_q[0];
      s1_d.top    = r_is1;
      s1_d.bedge  = !r_lt;
    end

    if (load) begin
      if (is_final) begin
        c_d = '0;
        r_d = '0;
      end else if (wrap) begin
        c_d = '0;
        r_d = r_q + RW'(1);
      end else begin
        c_d = c_q + CW'(1);
      end
    end

    if (load) begin
      s1_valid_d = 1'b1;
    end else if (win_ready_i) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q        <= '0;
      r_q        <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      c_q        <= c_d;
      r_q        <= r_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_q      <= s1_d;
      s1_addr_q <= c_q;
    end
  end

  assign ram_re_o    = load && !is_final;
  assign ram_raddr_o = c_q;
  assign s1_valid_o  = s1_valid_q;
  assign s1_o        = s1_q;
  assign s1_addr_o   = s1_addr_q;

endmodule

@@ design/bbd_window.sv @@
// ----------------------------------------------------------------------------
// bbd_window
// Line store read-modify-write with forwarding, window columns and
// edge-resolved neighborhood register.
// ----------------------------------------------------------------------------
module bbd_window import bbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s1_valid_i,
  input  bbd_s1_t          s1_i,
  input  logic [ROW_W-1:0] ram_rdata_i,
  output logic             ram_we_o,
  output logic [ROW_W-1:0] ram_wdata_o,
  output logic             win_ready_o,
  output logic             nb_valid_o,
  output bbd_nbhd_t        nb_o,
  input  logic             nb_ready_i
);

  typedef logic [2:0][PIX_W-1:0] col_t;   // rows top, middle, bottom

  col_t             win1_q, win2_q;
  col_t             new_col, lcol, ccol, rcol;
  logic [ROW_W-1:0] word, wdata_q;
  logic [1:0]       ti, bi;
  logic             fire;
  logic             nb_valid_q, nb_valid_d;
  bbd_nbhd_t        nb_q, nb_d;

  assign win_ready_o = !nb_valid_q || nb_ready_i;
  assign fire        = s1_valid_i && win_ready_o;

  assign word = s1_i.fwd ? wdata_q : ram_rdata_i;

  always_comb begin
    new_col[0] = word[ROW_W-1:PIX_W];
    new_col[1] = word[PIX_W-1:0];
    new_col[2] = s1_i.wr ? s1_i.pix : word[PIX_W-1:0];

    ccol = win2_q;
    lcol = s1_i.ledge ? win2_q : win1_q;
    if (s1_i.redge) begin
      rcol = win2_q;
    end else begin
      rcol = s1_i.pre ? win2_q : new_col;
    end
    ti = s1_i.top ? 2'd1 : 2'd0;
    bi = s1_i.bedge ? 2'd1 : 2'd2;

    nb_d.ctr    = ccol[1];
    nb_d.lm     = lcol[1];
    nb_d.rm     = rcol[1];
    nb_d.ct     = ccol[ti];
    nb_d.cb     = ccol[bi];
    nb_d.lt     = lcol[ti];
    nb_d.rt     = rcol[ti];
    nb_d.lb     = lcol[bi];
    nb_d.rb     = rcol[bi];
    nb_d.ox_lsb = s1_i.ox_lsb;
    nb_d.oy_lsb = s1_i.oy_lsb;
    nb_d.eof    = s1_i.redge && s1_i.bedge;

    if (fire && s1_i.emit) begin
      nb_valid_d = 1'b1;
    end else if (nb_ready_i) begin
      nb_valid_d = 1'b0;
    end else begin
      nb_valid_d = nb_valid_q;
    end
  end

  assign ram_we_o    = fire && s1_i.wr;
  assign ram_wdata_o = {word[PIX_W-1:0], s1_i.pix};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win1_q     <= '0;
      win2_q     <= '0;
      nb_valid_q <= 1'b0;
    end else begin
      nb_valid_q <= nb_valid_d;
      if (fire && s1_i.shift) begin
        win1_q <= win2_q;
        win2_q <= new_col;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we_o) begin
      wdata_q <= ram_wdata_o;
    end
    if (fire && s1_i.emit) begin
      nb_q <= nb_d;
    end
  end

  assign nb_valid_o = nb_valid_q;
  assign nb_o       = nb_q;

endmodule

@@ design/bbd_interp.sv @@
// ----------------------------------------------------------------------------
// bbd_interp
// Bilinear averages, color selection by filter phase, output register.
// ----------------------------------------------------------------------------
module bbd_interp import bbd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [PHASE_W-1:0]     filter_phase_i,
  input  logic                   nb_valid_i,
  input  bbd_nbhd_t              nb_i,
  output logic                   nb_ready_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);

  logic [PIX_W+1:0] cross_sum, diag_sum;
  logic [PIX_W:0]   horiz_sum, vert_sum;
  logic [PIX_W-1:0] cross_avg, diag, horiz, vert;
  logic [PIX_W-1:0] red_d, green_d, blue_d, red_q, green_q, blue_q;
  colour_e          col, ncol;
  logic             ov_q, eof_q, load;

  assign nb_ready_o = !ov_q || m_axis_tready;
  assign load       = nb_valid_i && nb_ready_o;

  always_comb begin
    cross_sum = (PIX_W+2)'(nb_i.lm) + (PIX_W+2)'(nb_i.rm) + (PIX_W+2)'(nb_i.ct)
              + (PIX_W+2)'(nb_i.cb) + (PIX_W+2)'(2);
    diag_sum  = (PIX_W+2)'(nb_i.lt) + (PIX_W+2)'(nb_i.rt) + (PIX_W+2)'(nb_i.lb)
              + (PIX_W+2)'(nb_i.rb) + (PIX_W+2)'(2);
    horiz_sum = (PIX_W+1)'(nb_i.lm) + (PIX_W+1)'(nb_i.rm) + (PIX_W+1)'(1);
    vert_sum  = (PIX_W+1)'(nb_i.ct) + (PIX_W+1)'(nb_i.cb) + (PIX_W+1)'(1);
    cross_avg = cross_sum[PIX_W+1:2];
    diag      = diag_sum[PIX_W+1:2];
    horiz     = horiz_sum[PIX_W:1];
    vert      = vert_sum[PIX_W:1];

    col  = colour_of(filter_phase_i[1:0], nb_i.oy_lsb, nb_i.ox_lsb);
    ncol = colour_of(filter_phase_i[1:0], nb_i.oy_lsb, ~nb_i.ox_lsb);

    red_d   = nb_i.ctr;
    green_d = nb_i.ctr;
    blue_d  = nb_i.ctr;
    if (!filter_phase_i[2]) begin
      case (col)
        COL_RED: begin
          green_d = cross_avg;
          blue_d  = diag;
        end
        COL_BLUE: begin
          green_d = cross_avg;
          red_d   = diag;
        end
        COL_GREEN: begin
          if (ncol == COL_RED) begin
            red_d  = horiz;
            blue_d = vert;
          end else begin
            blue_d = horiz;
            red_d  = vert;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (nb_ready_o) begin
      ov_q <= nb_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      eof_q   <= nb_i.eof;
    end
  end

  assign m_axis_tvalid = ov_q;
  // every item gives at most one pixel, so end of run is always set
  assign m_axis_tdata  = OUT_TDATA_W'({1'b1, blue_q, green_q, red_q});
  assign m_axis_tlast  = eof_q;

endmodule

@@ design/bayer_bilinear_demosaic.sv @@
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic
// Streaming 3x3 bilinear Bayer demosaic, raw 8-bit in, RGB 8-bit out.
//
//   port group   dir  tdata                                  tuser   tlast
//   s_axis       in   [7:0] raw_pixel                        opcode  -
//   m_axis       out  [7:0] red [15:8] green [23:16] blue    -       end_of_frame
//                     [24] end_of_run, [31:25] zero
//   cfg          in   cfg_we_i, cfg_index_i, cfg_data_i (write only)
//
// One request per cycle sustained while m_axis is ready. A pixel leaves via
// line store read, window, output register after the request completing it.
// Output trails input by one row plus one pixel; drain requests flush it.
// Line stores hold no reset, so no clearing pass; ready from reset.
// A stalled m_axis backs up through three one-deep stages to s_axis_tready.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic import bbd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] raw_pixel
  input  logic                   s_axis_tuser,   // [0] opcode
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // red, green, blue, end_of_run
  output logic                   m_axis_tlast
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [CFG_DATA_W-1:0] frame_width_q, frame_height_q;
  logic [PHASE_W-1:0]    filter_phase_q;

  logic             ram_re, ram_we;
  logic [CW-1:0]    ram_raddr, s1_addr;
  logic [ROW_W-1:0] ram_rdata, ram_wdata;
  logic             s1_valid, win_ready, nb_valid, nb_ready;
  bbd_s1_t          s1;
  bbd_nbhd_t        nb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= RST_FRAME_WIDTH;
      frame_height_q <= RST_FRAME_HEIGHT;
      filter_phase_q <= RST_FILTER_PHASE;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        CFG_FILTER_PHASE: filter_phase_q <= cfg_data_i[PHASE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bbd_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .win_ready_i    (win_ready),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .s1_valid_o     (s1_valid),
    .s1_o           (s1),
    .s1_addr_o      (s1_addr)
  );

  // upper row in the high byte, middle row in the low byte
  bbd_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bbd_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_i        (s1),
    .ram_rdata_i (ram_rdata),
    .ram_we_o    (ram_we),
    .ram_wdata_o (ram_wdata),
    .win_ready_o (win_ready),
    .nb_valid_o  (nb_valid),
    .nb_o        (nb),
    .nb_ready_i  (nb_ready)
  );

  bbd_interp u_interp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .filter_phase_i (filter_phase_q),
    .nb_valid_i     (nb_valid),
    .nb_i           (nb),
    .nb_ready_o     (nb_ready),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast)
  );

  ap_fwd_on_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re && (s1_addr == ram_raddr) |=> s1.fwd)
    else $error("line store collision not forwarded");

  ap_write_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> s1_valid && s1.wr)
    else $error("line store write without a pending request");

  ap_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_valid && !win_ready && nb_valid)
    else $error("input stalled without a full pipeline");

endmodule
